// ----- design/assert_macros.svh -----
// Assertion macros shared by the calibrator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define SPIC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPIC_ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPIC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPIC_ASSERT_ANY(lbl, clk, prop, msg)
`endif

`endif

// ----- design/spic_pkg.sv -----
package spic_pkg;

    localparam int TableDepthDef = 256;
    localparam int QW            = 17;
    localparam int RatioW        = 24;
    localparam int CountW        = 9;
    localparam int IdxW          = 8;
    localparam int CfgIdxW       = 2;
    localparam int RamWidthDef   = 2 * QW;

    localparam logic [QW-1:0]     Q16One   = 17'h10000;
    localparam logic [RatioW-1:0] RatioDef = 24'h010000;
    localparam logic [CountW-1:0] CountDef = 9'd1;

    typedef enum logic {
        OP_LOAD      = 1'b0,
        OP_CALIBRATE = 1'b1
    } t_op;

    typedef enum logic {
        MODE_UPPER = 1'b0,
        MODE_LOWER = 1'b1
    } t_mode;

    typedef enum logic [CfgIdxW-1:0] {
        REG_RATIO = 2'd0,
        REG_MODE  = 2'd1,
        REG_COUNT = 2'd2
    } t_reg;

    typedef struct packed {
        t_op              op;
        logic [IdxW-1:0]  index;
        logic [QW-1:0]    key;
        logic [QW-1:0]    value;
        logic [QW-1:0]    score;
    } t_cmd;

    typedef struct packed {
        logic [RatioW-1:0] ratio;
        t_mode             mode;
        logic [CountW-1:0] count;
    } t_cfg;

endpackage

// ----- design/spic_ram.sv -----
module spic_ram import spic_pkg::*; #(
    parameter int WIDTH = RamWidthDef,
    parameter int DEPTH = TableDepthDef
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/spic_front.sv -----
`include "assert_macros.svh"

module spic_front import spic_pkg::*; #(
    parameter int TABLE_DEPTH = TableDepthDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  t_op             i_operation,
    input  logic [IdxW-1:0] i_entry_index,
    input  logic [QW-1:0]   i_entry_key,
    input  logic [QW-1:0]   i_entry_value,
    input  logic [QW-1:0]   i_score,
    output logic            o_cmd_valid,
    output t_cmd            o_cmd,
    input  logic            i_cmd_pop
);

    t_cmd       r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       n_wr;
    logic       n_rd;
    logic [1:0] n_count;
    logic       w_accept;
    logic       w_keep;
    logic       w_take;
    t_cmd       w_cmd;

    assign o_full      = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_slot[r_rd];

    // Loads aimed past the table are dropped here and never reach the back end.
    assign w_accept = i_push & ~o_full;
    assign w_keep   = w_accept & ((i_operation == OP_CALIBRATE) ||
                                  (32'(i_entry_index) < TABLE_DEPTH));
    assign w_take   = i_cmd_pop & o_cmd_valid;

    always_comb begin
        w_cmd.op    = i_operation;
        w_cmd.index = i_entry_index;
        w_cmd.key   = i_entry_key;
        w_cmd.value = i_entry_value;
        w_cmd.score = (i_score > Q16One) ? Q16One : i_score;
    end

    always_comb begin
        n_wr    = r_wr ^ w_keep;
        n_rd    = r_rd ^ w_take;
        n_count = r_count + 2'(w_keep) - 2'(w_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_keep) begin
            r_slot[r_wr] <= w_cmd;
        end
    end

    `SPIC_ASSERT_ANY(a_reset_empties, i_clk, !i_rst_n |=> r_count == 2'd0, "queue not empty after reset")
    `SPIC_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= 2'd2, "command queue overflow")
    `SPIC_ASSERT(a_full_holds, i_clk, i_rst_n, (o_full && !i_cmd_pop) |=> o_full, "full queue lost an entry")

endmodule

// ----- design/spic_div.sv -----
`include "assert_macros.svh"

module spic_div import spic_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [QW-1:0]     i_score,
    input  logic [RatioW-1:0] i_ratio,
    output logic              o_done,
    output logic [QW-1:0]     o_quot
);

    localparam int NumW = QW - 1 + RatioW;
    localparam int DenW = NumW + 1;
    localparam int DvdW = NumW + 17;

    typedef enum logic [4:0] {
        D_IDLE = 5'b00001,
        D_MUL  = 5'b00010,
        D_DEN  = 5'b00100,
        D_INIT = 5'b01000,
        D_ITER = 5'b10000
    } t_dstate;

    t_dstate           r_state;
    t_dstate           n_state;
    logic [QW-1:0]     r_s;
    logic [RatioW-1:0] r_r;
    logic [NumW-1:0]   r_num;
    logic [DenW-1:0]   r_den;
    logic [DenW-1:0]   r_rem;
    logic [QW-1:0]     r_low;
    logic [4:0]        r_cnt;
    logic              r_done;
    logic [NumW:0]     w_prod;
    logic [DvdW-1:0]   w_dvd;
    logic [DenW:0]     w_trial;
    logic              w_ge;

    assign w_prod  = r_s * r_r;
    assign w_dvd   = {1'b0, r_num, 16'b0} + DvdW'(r_den[DenW-1:1]);
    assign w_trial = {r_rem, r_low[QW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE: if (i_start) n_state = D_MUL;
            D_MUL:  n_state = D_DEN;
            D_DEN:  n_state = D_INIT;
            D_INIT: n_state = D_ITER;
            D_ITER: if (r_cnt == 5'd1) n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == D_ITER) && (r_cnt == 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            D_IDLE: begin
                r_s <= i_score;
                r_r <= (i_ratio == '0) ? RatioW'(1) : i_ratio;
            end
            D_MUL: r_num <= w_prod[NumW-1:0];
            D_DEN: r_den <= {1'b0, r_num} + DenW'({Q16One - r_s, 16'b0});
            D_INIT: begin
                r_rem <= {1'b0, w_dvd[DvdW-1:QW]};
                r_low <= w_dvd[QW-1:0];
                r_cnt <= 5'(QW);
            end
            D_ITER: begin
                r_rem <= w_ge ? DenW'(w_trial - {1'b0, r_den}) : w_trial[DenW-1:0];
                r_low <= {r_low[QW-2:0], w_ge};
                r_cnt <= r_cnt - 5'd1;
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    assign o_done = r_done;
    assign o_quot = r_low;

    `SPIC_ASSERT(a_start_idle, i_clk, i_rst_n, i_start |-> r_state == D_IDLE, "divider started while busy")
    `SPIC_ASSERT(a_rem_below, i_clk, i_rst_n, r_state == D_ITER |-> r_rem < r_den, "partial remainder not below divisor")
    `SPIC_ASSERT(a_quot_range, i_clk, i_rst_n, o_done |-> o_quot <= Q16One, "corrected score above one")

endmodule

// ----- design/spic_back.sv -----
`include "assert_macros.svh"

module spic_back import spic_pkg::*; #(
    parameter int TABLE_DEPTH = TableDepthDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    input  logic            i_cmd_valid,
    input  t_cmd            i_cmd,
    output logic            o_cmd_pop,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [QW-1:0]   o_calibrated_score,
    output logic [IdxW-1:0] o_found_index
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_DIV  = 7'b0000010,
        B_SRD  = 7'b0000100,
        B_SCMP = 7'b0001000,
        B_VRD  = 7'b0010000,
        B_VGET = 7'b0100000,
        B_PUSH = 7'b1000000
    } t_bstate;

    t_bstate           r_state;
    t_bstate           n_state;
    logic [QW-1:0]     r_key;
    logic [QW-1:0]     n_key;
    logic [CW-1:0]     r_first;
    logic [CW-1:0]     n_first;
    logic [CW-1:0]     r_len;
    logic [CW-1:0]     n_len;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     n_idx;
    logic [QW-1:0]     r_value;
    logic [QW-1:0]     n_value;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [QW-1:0]     r_out_score;
    logic [QW-1:0]     n_out_score;
    logic [IdxW-1:0]   r_out_index;
    logic [IdxW-1:0]   n_out_index;
    logic [CW-1:0]     w_n;
    logic [CW-1:0]     w_nm1;
    logic [CW-1:0]     w_half;
    logic [CW-1:0]     w_mid;
    logic [AW-1:0]     w_idx_c;
    logic [QW-1:0]     w_mid_key;
    logic              w_go_right;
    logic              w_load;
    logic              w_start;
    logic              w_div_done;
    logic [QW-1:0]     w_quot;
    logic [2*QW-1:0]   w_rd_data;
    logic [AW-1:0]     w_raddr;

    always_comb begin
        if (i_cfg.count == '0) begin
            w_n = CW'(1);
        end else if (32'(i_cfg.count) > TABLE_DEPTH) begin
            w_n = CW'(TABLE_DEPTH);
        end else begin
            w_n = CW'(i_cfg.count);
        end
    end

    assign w_nm1     = w_n - CW'(1);
    assign w_half    = r_len >> 1;
    assign w_mid     = r_first + w_half;
    assign w_idx_c   = (r_first > w_nm1) ? AW'(w_nm1) : AW'(r_first);
    assign w_mid_key = w_rd_data[2*QW-1:QW];
    assign w_go_right = (i_cfg.mode == MODE_UPPER) ? !(w_mid_key > r_key)
                                                   : (w_mid_key < r_key);

    assign o_cmd_pop = (r_state == B_IDLE) && i_cmd_valid;
    assign w_load    = o_cmd_pop && (i_cmd.op == OP_LOAD);
    assign w_start   = o_cmd_pop && (i_cmd.op == OP_CALIBRATE);
    assign w_raddr   = (r_state == B_SRD) ? AW'(w_mid) : w_idx_c;

    spic_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_score (i_cmd.score),
        .i_ratio (i_cfg.ratio),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    spic_ram #(
        .WIDTH (2 * QW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (AW'(32'(i_cmd.index))),
        .i_wdata ({i_cmd.key, i_cmd.value}),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_first     = r_first;
        n_len       = r_len;
        n_idx       = r_idx;
        n_value     = r_value;
        n_out_valid = r_out_valid & ~i_pop;
        n_out_score = r_out_score;
        n_out_index = r_out_index;
        unique case (r_state)
            B_IDLE: begin
                if (w_start) n_state = B_DIV;
            end
            B_DIV: begin
                if (w_div_done) begin
                    n_key   = w_quot;
                    n_first = '0;
                    n_len   = (i_cfg.mode == MODE_UPPER) ? w_nm1 : w_n;
                    n_state = (n_len == '0) ? B_VRD : B_SRD;
                end
            end
            B_SRD: begin
                n_state = B_SCMP;
            end
            B_SCMP: begin
                if (w_go_right) begin
                    n_first = w_mid + CW'(1);
                    n_len   = r_len - w_half - CW'(1);
                end else begin
                    n_len = w_half;
                end
                n_state = (n_len == '0) ? B_VRD : B_SRD;
            end
            B_VRD: begin
                n_idx   = w_idx_c;
                n_state = B_VGET;
            end
            B_VGET: begin
                n_value = w_rd_data[QW-1:0];
                n_state = B_PUSH;
            end
            B_PUSH: begin
                if (!r_out_valid || i_pop) begin
                    n_out_valid = 1'b1;
                    n_out_score = r_value;
                    n_out_index = IdxW'(32'(r_idx));
                    n_state     = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_first     <= n_first;
        r_len       <= n_len;
        r_idx       <= n_idx;
        r_value     <= n_value;
        r_out_score <= n_out_score;
        r_out_index <= n_out_index;
    end

    assign o_empty            = ~r_out_valid;
    assign o_calibrated_score = r_out_score;
    assign o_found_index      = r_out_index;

    `SPIC_ASSERT(a_len_live, i_clk, i_rst_n, r_state == B_SCMP |-> r_len != '0, "probe with an empty range")
    `SPIC_ASSERT(a_mid_range, i_clk, i_rst_n, r_state == B_SRD |-> w_mid < w_n, "probe past the entries in use")
    `SPIC_ASSERT(a_out_hold, i_clk, i_rst_n, (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out_score)), "waiting result changed")
    `SPIC_ASSERT(a_push_fresh, i_clk, i_rst_n, (r_state == B_PUSH && r_out_valid && !i_pop) |=> r_state == B_PUSH, "result overwritten")

endmodule

// ----- design/score_prior_isotonic_calibrator_unit.sv -----
// Score calibrator. A calibrate request corrects its score for negative
// subsampling, c = s*r / (s*r + 1 - s) rounded to nearest in Q1.16, then
// binary-searches the bin keys (upper or lower bound, set by the mode
// register) and returns the bin value and the index found. A load request
// writes one key and value pair into the table and returns nothing; slots at
// or past TABLE_DEPTH are ignored. Requests are handled one at a time: a load
// is written into the table as the back end takes it, and a calibrate runs
// the multiply, the denominator, the divider set-up, the 17-step serial
// divider and its done flag, then a registered table read and a compare per
// search probe (eight probes at 256 entries in upper-bound mode, up to nine
// in lower-bound mode), then a read of the value and a post to the output
// register, which waits while that register still holds an unpopped result.
// A two-entry request queue lets pushes continue while a request is being
// worked, and one output register holds the result until popped.
// Configuration writes belong only to idle periods.
module score_prior_isotonic_calibrator_unit import spic_pkg::*; #(
    parameter int TABLE_DEPTH = TableDepthDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_operation,
    input  logic [IdxW-1:0]    i_entry_index,
    input  logic [QW-1:0]      i_entry_key,
    input  logic [QW-1:0]      i_entry_value,
    input  logic [QW-1:0]      i_score,
    output logic               empty,
    input  logic               pop,
    output logic [QW-1:0]      o_calibrated_score,
    output logic [IdxW-1:0]    o_found_index,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [RatioW-1:0]  i_cfg_wdata
);

    t_cfg r_cfg;
    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ratio <= RatioDef;
            r_cfg.mode  <= MODE_UPPER;
            r_cfg.count <= CountDef;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_RATIO) r_cfg.ratio <= i_cfg_wdata;
            if (i_cfg_idx == REG_MODE)  r_cfg.mode  <= t_mode'(i_cfg_wdata[0]);
            if (i_cfg_idx == REG_COUNT) r_cfg.count <= i_cfg_wdata[CountW-1:0];
        end
    end

    spic_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_operation   (t_op'(i_operation)),
        .i_entry_index (i_entry_index),
        .i_entry_key   (i_entry_key),
        .i_entry_value (i_entry_value),
        .i_score       (i_score),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    spic_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_cmd_valid        (w_cmd_valid),
        .i_cmd              (w_cmd),
        .o_cmd_pop          (w_cmd_pop),
        .o_empty            (empty),
        .i_pop              (pop),
        .o_calibrated_score (o_calibrated_score),
        .o_found_index      (o_found_index)
    );

endmodule

// ----- sim/score_prior_isotonic_calibrator_unit_tb.sv -----
`timescale 1ns / 100ps

module score_prior_isotonic_calibrator_unit_tb import spic_pkg::*; ;

    localparam int TableDepth     = TableDepthDef;
    localparam int ItemTarget     = 1900;
    localparam int QuietTailItems = 250;
    localparam int DrainCycles    = 64;
    localparam int HoldOffCycles  = 400;
    localparam int WatchdogLimit  = 4000;
    localparam int ReportLimit    = 10;
    localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

    typedef struct packed {
        logic [QW-1:0]   value;
        logic [IdxW-1:0] index;
    } t_calib_result;

    class t_calibration_scoreboard;
        logic [QW-1:0]     key_tab [TableDepth];
        logic [QW-1:0]     value_tab [TableDepth];
        logic [RatioW-1:0] ratio;
        t_mode             mode;
        logic [CountW-1:0] count;
        t_calib_result     pending_calibrations [$];
        int                mismatches;

        function new();
            foreach (key_tab[i]) begin
                key_tab[i]   = '0;
                value_tab[i] = '0;
            end
            ratio      = RatioDef;
            mode       = MODE_UPPER;
            count      = CountDef;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CfgIdxW-1:0] idx, logic [RatioW-1:0] data);
            case (idx)
                REG_RATIO: ratio = data;
                REG_MODE:  mode = t_mode'(data[0]);
                REG_COUNT: count = data[CountW-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_calibrations.size();
        endfunction

        // Prior correction rounded to nearest, halves up, in Q1.16.
        function logic [QW-1:0] corrected_score(logic [QW-1:0] raw);
            logic [63:0] s, r, num, den, quo;
            s   = (raw > Q16One) ? 64'(Q16One) : 64'(raw);
            r   = (ratio == '0) ? 64'd1 : 64'(ratio);
            num = s * r;
            den = num + ((64'(Q16One) - s) << 16);
            quo = ((num << 16) + (den >> 1)) / den;
            return quo[QW-1:0];
        endfunction

        function int upper_bound_index(logic [QW-1:0] c, int n);
            int lo, span, half, mid;
            lo   = 0;
            span = n - 1;
            while (span > 0) begin
                half = span / 2;
                mid  = lo + half;
                if (key_tab[mid] > c) begin
                    span = half;
                end else begin
                    lo   = mid + 1;
                    span = span - half - 1;
                end
            end
            return lo;
        endfunction

        function int lower_bound_index(logic [QW-1:0] c, int n);
            int lo, span, half, mid;
            lo   = 0;
            span = n;
            while (span > 0) begin
                half = span / 2;
                mid  = lo + half;
                if (key_tab[mid] < c) begin
                    lo   = mid + 1;
                    span = span - half - 1;
                end else begin
                    span = half;
                end
            end
            return (lo > n - 1) ? n - 1 : lo;
        endfunction

        function void record_request(t_cmd cmd);
            t_calib_result awaited;
            logic [QW-1:0] c;
            int n, idx;
            if (cmd.op == OP_LOAD) begin
                key_tab[cmd.index]   = cmd.key;
                value_tab[cmd.index] = cmd.value;
            end else begin
                n = (count == '0) ? 1 : (count > TableDepth) ? TableDepth : int'(count);
                c = corrected_score(cmd.score);
                idx = (mode == MODE_UPPER) ? upper_bound_index(c, n)
                                           : lower_bound_index(c, n);
                awaited.value = value_tab[idx];
                awaited.index = IdxW'(idx);
                pending_calibrations = {pending_calibrations, awaited};
            end
        endfunction

        function void check_result(t_calib_result got);
            t_calib_result awaited;
            if (pending_calibrations.size() == 0) begin
                mismatches++;
                if (mismatches <= ReportLimit)
                    $display("%0t: unexpected result value %h index %0d",
                             $realtime, got.value, got.index);
            end else begin
                awaited = pending_calibrations.pop_front();
                if (got !== awaited) begin
                    mismatches++;
                    if (mismatches <= ReportLimit)
                        $display("%0t: expected value %h index %0d, got value %h index %0d",
                                 $realtime, awaited.value, awaited.index,
                                 got.value, got.index);
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic               i_operation;
    logic [IdxW-1:0]    i_entry_index;
    logic [QW-1:0]      i_entry_key;
    logic [QW-1:0]      i_entry_value;
    logic [QW-1:0]      i_score;
    logic               empty;
    logic               pop;
    logic [QW-1:0]      o_calibrated_score;
    logic [IdxW-1:0]    o_found_index;
    logic               i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_idx;
    logic [RatioW-1:0]  i_cfg_wdata;

    t_calibration_scoreboard sb = new();

    logic [QW-1:0] stim_key [TableDepth];
    int            active_entries = 1;
    int            sent_count = 0;
    int            quiet_cycles = 0;
    bit            gaps_on = 1'b1;
    bit            hold_req = 1'b0;

    score_prior_isotonic_calibrator_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_operation        (i_operation),
        .i_entry_index      (i_entry_index),
        .i_entry_key        (i_entry_key),
        .i_entry_value      (i_entry_value),
        .i_score            (i_score),
        .empty              (empty),
        .pop                (pop),
        .o_calibrated_score (o_calibrated_score),
        .o_found_index      (o_found_index),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_cmd          seen;
        t_calib_result got;
        if (i_rst_n) begin
            if (i_cfg_we) sb.set_reg(i_cfg_idx, i_cfg_wdata);
            if (push && !full) begin
                seen.op    = t_op'(i_operation);
                seen.index = i_entry_index;
                seen.key   = i_entry_key;
                seen.value = i_entry_value;
                seen.score = i_score;
                sb.record_request(seen);
            end
            if (pop && !empty) begin
                got.value = o_calibrated_score;
                got.index = o_found_index;
                sb.check_result(got);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        pop <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HoldOffCycles) @(posedge i_clk);
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_request(input t_cmd cmd);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_operation   <= cmd.op;
        i_entry_index <= cmd.index;
        i_entry_key   <= cmd.key;
        i_entry_value <= cmd.value;
        i_score       <= cmd.score;
        do @(posedge i_clk); while (full);
        sent_count++;
    endtask

    task automatic load_entry(input int slot, input logic [QW-1:0] key,
                              input logic [QW-1:0] value);
        t_cmd cmd;
        cmd.op    = OP_LOAD;
        cmd.index = IdxW'(slot);
        cmd.key   = key;
        cmd.value = value;
        cmd.score = QW'($urandom_range(0, 17'h1FFFF));
        stim_key[slot] = key;
        send_request(cmd);
    endtask

    task automatic calibrate(input logic [QW-1:0] score);
        t_cmd cmd;
        cmd.op    = OP_CALIBRATE;
        cmd.index = IdxW'($urandom_range(0, 255));
        cmd.key   = QW'($urandom_range(0, 17'h1FFFF));
        cmd.value = QW'($urandom_range(0, 17'h1FFFF));
        cmd.score = score;
        send_request(cmd);
    endtask

    // Wait until every calibration has returned, then let any trailing load finish.
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic configure(input logic [RatioW-1:0] ratio, input t_mode mode,
                             input logic [CountW-1:0] count);
        logic [RatioW-1:0] pad;
        pad = RatioW'($urandom_range(0, 24'hFFFFFF));
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_RATIO;
        i_cfg_wdata <= ratio;
        @(posedge i_clk);
        i_cfg_idx   <= REG_MODE;
        i_cfg_wdata <= {pad[RatioW-1:1], mode};
        @(posedge i_clk);
        i_cfg_idx   <= REG_COUNT;
        i_cfg_wdata <= {pad[RatioW-1:CountW], count};
        @(posedge i_clk);
        i_cfg_idx   <= RegUnused;
        i_cfg_wdata <= pad;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        active_entries = (count == '0) ? 1 : (count > TableDepth) ? TableDepth : int'(count);
    endtask

    task automatic build_table(input int m, input bit ordered);
        int key, value, i;
        key   = $urandom_range(0, 65536 / m);
        value = $urandom_range(0, 65536 / m);
        for (i = 0; i < m; i++) begin
            if (ordered) begin
                load_entry(i, QW'(key), QW'(value));
                key   = key + $urandom_range(0, 2 * 65536 / m);
                value = value + $urandom_range(0, 2 * 65536 / m);
                if (key > 65536) key = 65536;
                if (value > 65536) value = 65536;
            end else begin
                load_entry(i, QW'($urandom_range(0, 17'h1FFFF)),
                           QW'($urandom_range(0, 17'h1FFFF)));
            end
        end
    endtask

    // Rewrite one slot, mostly with a key that keeps the table ascending.
    task automatic load_near(input int n);
        int slot, lo, hi;
        slot = $urandom_range(0, n - 1);
        lo   = (slot == 0) ? 0 : int'(stim_key[slot - 1]);
        hi   = (slot == TableDepth - 1) ? 65536 : int'(stim_key[slot + 1]);
        if ($urandom_range(0, 7) == 0)
            load_entry(slot, QW'($urandom_range(0, 17'h1FFFF)),
                       QW'($urandom_range(0, 17'h1FFFF)));
        else
            load_entry(slot, QW'($urandom_range(hi, lo)), QW'($urandom_range(0, 65536)));
    endtask

    function automatic logic [QW-1:0] pick_score(int n);
        int probe;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return Q16One;
            2: return QW'($urandom_range(65537, 17'h1FFFF));
            3, 4, 5: begin
                probe = int'(stim_key[$urandom_range(0, n - 1)]) + $urandom_range(0, 2) - 1;
                return QW'(probe);
            end
            default: return QW'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [RatioW-1:0] pick_ratio();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 24'd1;
            2: return 24'hFFFFFF;
            3, 4: return RatioDef;
            5: return RatioW'($urandom_range(0, 24'hFFFFFF));
            default: return RatioW'($urandom_range(24'h002000, 24'h080000));
        endcase
    endfunction

    function automatic logic [CountW-1:0] pick_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 9'd1;
            2: return 9'd2;
            3: return 9'd256;
            4: return CountW'($urandom_range(257, 511));
            5: return 9'd255;
            6, 7: return CountW'($urandom_range(1, 16));
            default: return CountW'($urandom_range(1, 256));
        endcase
    endfunction

    initial begin
        int phase, batch;
        i_rst_n       <= 1'b0;
        push          <= 1'b0;
        i_operation   <= OP_LOAD;
        i_entry_index <= '0;
        i_entry_key   <= '0;
        i_entry_value <= '0;
        i_score       <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_RATIO;
        i_cfg_wdata   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Small table with a repeated key and a key at one.
        load_entry(0, 17'h00000, 17'h00000);
        load_entry(1, 17'h04000, 17'h05555);
        load_entry(2, 17'h04000, 17'h0AAAA);
        load_entry(3, 17'h10000, 17'h10000);
        calibrate(17'h04000);

        settle();
        configure(RatioDef, MODE_UPPER, 9'd4);
        calibrate(17'h00000);
        calibrate(17'h03FFF);
        calibrate(17'h04000);
        calibrate(17'h10000);
        calibrate(17'h1FFFF);

        // Lower bound running past the end gets clamped to the last entry.
        settle();
        configure(RatioDef, MODE_LOWER, 9'd3);
        calibrate(17'h00000);
        calibrate(17'h04000);
        calibrate(17'h10000);

        // A zero ratio acts as the smallest ratio and a zero count as one entry.
        settle();
        configure('0, MODE_LOWER, 9'd0);
        calibrate(17'h10000);
        calibrate(17'h08000);

        settle();
        configure(24'hFFFFFF, MODE_UPPER, 9'd4);
        calibrate(17'h00001);

        settle();
        configure(RatioDef, MODE_UPPER, 9'd256);
        build_table(TableDepth, 1'b1);

        phase = 0;
        while (sent_count < ItemTarget) begin
            if (ItemTarget - sent_count < QuietTailItems) gaps_on = 1'b0;
            // The tail keeps the last configuration and runs without pauses.
            if (gaps_on) begin
                settle();
                configure(pick_ratio(), t_mode'($urandom_range(0, 1)), pick_count());
                if ($urandom_range(0, 3) == 0)
                    build_table(active_entries, $urandom_range(0, 4) != 0);
            end
            if (phase == 2) hold_req = 1'b1;
            batch = $urandom_range(30, 80);
            repeat (batch) begin
                if ($urandom_range(0, 9) < 7) calibrate(pick_score(active_entries));
                else load_near(active_entries);
            end
            phase++;
        end

        settle();
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
